// File: hw/rtl/cslu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed subimage unpack layout: shared package
// Payload types, register indexes and divider constants.
// ----------------------------------------------------------------------------
package cslu_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_BYTES    = 3'd0,
    CFG_BLOCK_W        = 3'd1,
    CFG_BLOCK_H        = 3'd2,
    CFG_BLOCK_D        = 3'd3,
    CFG_SKIP_PX        = 3'd4,
    CFG_ROW_LEN        = 3'd5,
    CFG_SKIP_ROW_COUNT = 3'd6,
    CFG_IMG_HEIGHT     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] tex_width;
    logic [14:0] tex_height;
    logic [11:0] tex_depth;
    logic [30:0] given_size;
    logic        subimage_ok;
    logic [11:0] skip_img;
  } in_item_t;

  typedef struct packed {
    logic        fast_path;
    logic [47:0] skip_offset;
    logic [18:0] copy_row_bytes;
    logic [18:0] row_pitch;
    logic [14:0] copy_rows;
    logic [14:0] slice_rows;
    logic [11:0] copy_slice_count;
    logic [47:0] total_bytes;
  } out_item_t;

  // Small dividers: quotient of a 16-bit value by a 4-bit block dimension
  // through a reciprocal multiply and one correction step.
  localparam int unsigned NumSdiv    = 7;
  localparam int unsigned SdivW      = 16;
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RecipShift = 16;

  localparam int unsigned SD_WIDTH      = 0;
  localparam int unsigned SD_ROW_LEN    = 1;
  localparam int unsigned SD_SKIP_PX    = 2;
  localparam int unsigned SD_HEIGHT     = 3;
  localparam int unsigned SD_IMG_HEIGHT = 4;
  localparam int unsigned SD_SKIP_ROWS  = 5;
  localparam int unsigned SD_DEPTH      = 6;

  // Long divider: 48-bit value by the block depth, one digit per stage.
  localparam int unsigned LdivW      = 48;
  localparam int unsigned LdivDigit  = 4;
  localparam int unsigned LdivStages = LdivW / LdivDigit;

  // floor(2^16 / b); a zero divisor counts as one.
  function automatic logic [RecipW-1:0] recip(input logic [3:0] b);
    logic [RecipW-1:0] r;
    case (b)
      4'd0, 4'd1: r = 17'd65536;
      4'd2:       r = 17'd32768;
      4'd3:       r = 17'd21845;
      4'd4:       r = 17'd16384;
      4'd5:       r = 17'd13107;
      4'd6:       r = 17'd10922;
      4'd7:       r = 17'd9362;
      4'd8:       r = 17'd8192;
      4'd9:       r = 17'd7281;
      4'd10:      r = 17'd6553;
      4'd11:      r = 17'd5957;
      4'd12:      r = 17'd5461;
      4'd13:      r = 17'd5041;
      4'd14:      r = 17'd4681;
      default:    r = 17'd4369;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/cslu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed subimage unpack layout: channel interfaces
// Valid/ready channels for requests and layout results.
// ----------------------------------------------------------------------------
interface cslu_in_if;
  logic               valid;
  logic               ready;
  cslu_pkg::in_item_t item;

  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface cslu_out_if;
  logic                valid;
  logic                ready;
  cslu_pkg::out_item_t item;

  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

// File: hw/rtl/compressed_subimage_unpack_layout_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed subimage unpack layout
// Decides whether unpack settings can be ignored for a compressed texture
// upload and otherwise computes the strided copy layout.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_i and layout results leave on out_o, both valid/ready
// channels; a transfer happens on an edge with valid and ready high. The
// unpack settings and block format are written through cfg_we_i, cfg_idx_i
// and cfg_data_i while no request is in flight.
// Every request gives exactly one result, in order. A result passes through
// six preparation stages (reciprocal division by the block size, layout
// products), twelve stages of the depth divider that retires four quotient
// bits per stage, one sum stage and the output register before it can leave on
// out_o. One request is taken per cycle unless out_o stalls with the pipeline full.
// When out_o stalls, a stage holds only if it and every stage after it are
// full, so in_i stays ready until every stage up to the input is occupied; no
// transfer is lost or repeated. Reset empties the pipeline and loads the
// register defaults (block 1x1x1 with zero bytes, all unpack settings zero).
// ----------------------------------------------------------------------------
module compressed_subimage_unpack_layout_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cslu_in_if.sink                        in_i,
  cslu_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [cslu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cslu_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned StPrep   = 0;
  localparam int unsigned StRecip  = 1;
  localparam int unsigned StFix    = 2;
  localparam int unsigned StLayout = 3;
  localparam int unsigned StProd   = 4;
  localparam int unsigned StWide   = 5;
  localparam int unsigned StDiv0   = 6;
  localparam int unsigned StSum    = StDiv0 + cslu_pkg::LdivStages;
  localparam int unsigned NumSt    = StSum + 1;
  localparam int unsigned DivMsb   = cslu_pkg::LdivW - 1;

  typedef struct packed {
    logic                                                   fast;
    logic [30:0]                                            given;
    logic                                                   h_nz;
    logic                                                   d_nz;
    logic [11:0]                                            d;
    logic [11:0]                                            simg;
    logic [cslu_pkg::NumSdiv-1:0][cslu_pkg::SdivW-1:0]      num;
    logic [cslu_pkg::NumSdiv-1:0][cslu_pkg::SdivW-1:0]      quo;
    logic [19:0]                                            copy_row;
    logic [19:0]                                            pitch;
    logic [14:0]                                            crows;
    logic [14:0]                                            srows;
    logic [11:0]                                            slices;
    logic [19:0]                                            skip_a;
    logic [34:0]                                            skip_b;
    logic [34:0]                                            slice_bytes;
    logic [34:0]                                            pc;
    logic [11:0]                                            n1;
    logic [35:0]                                            sab;
    logic [DivMsb:0]                                        x1;
    logic [DivMsb:0]                                        x2;
    logic [2:0]                                             r1;
    logic [2:0]                                             r2;
    logic [47:0]                                            skip;
    logic [47:0]                                            tpart;
  } work_t;

  // Configuration registers
  logic [4:0]  bb_q;
  logic [3:0]  bw_q;
  logic [3:0]  bh_q;
  logic [2:0]  bd_q;
  logic [14:0] spx_q;
  logic [14:0] rl_q;
  logic [14:0] srow_q;
  logic [14:0] ih_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q   <= 5'd0;
      bw_q   <= 4'd1;
      bh_q   <= 4'd1;
      bd_q   <= 3'd1;
      spx_q  <= 15'd0;
      rl_q   <= 15'd0;
      srow_q <= 15'd0;
      ih_q   <= 15'd0;
    end else if (cfg_we_i) begin
      unique case (cslu_pkg::cfg_idx_e'(cfg_idx_i))
        cslu_pkg::CFG_BLOCK_BYTES:    bb_q   <= cfg_data_i[4:0];
        cslu_pkg::CFG_BLOCK_W:        bw_q   <= cfg_data_i[3:0];
        cslu_pkg::CFG_BLOCK_H:        bh_q   <= cfg_data_i[3:0];
        cslu_pkg::CFG_BLOCK_D:        bd_q   <= cfg_data_i[2:0];
        cslu_pkg::CFG_SKIP_PX:        spx_q  <= cfg_data_i;
        cslu_pkg::CFG_ROW_LEN:        rl_q   <= cfg_data_i;
        cslu_pkg::CFG_SKIP_ROW_COUNT: srow_q <= cfg_data_i;
        cslu_pkg::CFG_IMG_HEIGHT:     ih_q   <= cfg_data_i;
      endcase
    end
  end

  // Zero block dimensions count as one in every division.
  logic [3:0] bw1;
  logic [3:0] bh1;
  logic [2:0] bd1;
  logic [cslu_pkg::NumSdiv-1:0][3:0] sd_den;

  assign bw1 = (bw_q == 4'd0) ? 4'd1 : bw_q;
  assign bh1 = (bh_q == 4'd0) ? 4'd1 : bh_q;
  assign bd1 = (bd_q == 3'd0) ? 3'd1 : bd_q;

  always_comb begin
    sd_den[cslu_pkg::SD_WIDTH]      = bw1;
    sd_den[cslu_pkg::SD_ROW_LEN]    = bw1;
    sd_den[cslu_pkg::SD_SKIP_PX]    = bw1;
    sd_den[cslu_pkg::SD_HEIGHT]     = bh1;
    sd_den[cslu_pkg::SD_IMG_HEIGHT] = bh1;
    sd_den[cslu_pkg::SD_SKIP_ROWS]  = bh1;
    sd_den[cslu_pkg::SD_DEPTH]      = {1'b0, bd1};
  end

  // Pipeline registers and flow control
  work_t               stg_q [NumSt];
  work_t               stg_d [NumSt];
  logic [NumSt-1:0]    vld_q;
  logic [NumSt:0]      stage_en;
  cslu_pkg::out_item_t out_q;
  cslu_pkg::out_item_t out_d;
  logic                out_vld_q;

  // A stage loads when it is empty or when every stage after it moves on.
  assign stage_en[NumSt] = !out_vld_q || out_o.ready;
  for (genvar k = 0; k < NumSt; k++) begin : g_en
    assign stage_en[k] = stage_en[NumSt] || !(&vld_q[NumSt-1:k]);
  end

  assign in_i.ready  = stage_en[0];
  assign out_o.valid = out_vld_q;
  assign out_o.item  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (stage_en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumSt; k++) begin
        if (stage_en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (stage_en[NumSt]) begin
        out_vld_q <= vld_q[NumSt-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSt; k++) begin
      if (stage_en[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
    if (stage_en[NumSt]) begin
      out_q <= out_d;
    end
  end

  // Stage 0: fast path decision and rounded-up dividends
  always_comb begin
    work_t v;
    logic  fast_ok;
    cslu_pkg::in_item_t it;
    it = in_i.item;
    v  = '0;
    if (bb_q == 5'd0 || bw_q == 4'd0) begin
      fast_ok = 1'b1;
    end else if (spx_q != 15'd0) begin
      fast_ok = 1'b0;
    end else if (it.tex_width != 15'd0 && rl_q != 15'd0 && it.tex_width < rl_q) begin
      fast_ok = 1'b0;
    end else if (it.tex_height == 15'd0 || bh_q == 4'd0) begin
      fast_ok = 1'b1;
    end else if (srow_q != 15'd0) begin
      fast_ok = 1'b0;
    end else if (ih_q != 15'd0 && it.tex_height < ih_q) begin
      fast_ok = 1'b0;
    end else if (it.tex_depth == 12'd0 || bd_q == 3'd0) begin
      fast_ok = 1'b1;
    end else begin
      fast_ok = (it.skip_img == 12'd0);
    end
    v.fast  = !it.subimage_ok || fast_ok;
    v.given = it.given_size;
    v.h_nz  = (it.tex_height != 15'd0);
    v.d_nz  = (it.tex_depth != 12'd0);
    v.d     = it.tex_depth;
    v.simg  = it.skip_img;
    v.num[cslu_pkg::SD_WIDTH]      = 16'(it.tex_width) + 16'(bw1) - 16'd1;
    v.num[cslu_pkg::SD_ROW_LEN]    = 16'(rl_q) + 16'(bw1) - 16'd1;
    v.num[cslu_pkg::SD_SKIP_PX]    = 16'(spx_q);
    v.num[cslu_pkg::SD_HEIGHT]     = 16'(it.tex_height) + 16'(bh1) - 16'd1;
    v.num[cslu_pkg::SD_IMG_HEIGHT] = 16'(ih_q) + 16'(bh1) - 16'd1;
    v.num[cslu_pkg::SD_SKIP_ROWS]  = 16'(srow_q);
    v.num[cslu_pkg::SD_DEPTH]      = 16'(it.tex_depth) + 16'(bd1) - 16'd1;
    stg_d[StPrep] = v;
  end

  // Stage 1: reciprocal estimate, never more than one below the quotient
  always_comb begin
    work_t       v;
    logic [32:0] prod;
    v = stg_q[StPrep];
    for (int i = 0; i < cslu_pkg::NumSdiv; i++) begin
      prod = 33'(v.num[i]) * 33'(cslu_pkg::recip(sd_den[i]));
      v.quo[i] = prod[cslu_pkg::RecipShift +: cslu_pkg::SdivW];
    end
    stg_d[StRecip] = v;
  end

  // Stage 2: correct the estimate with one compare
  always_comb begin
    work_t       v;
    logic [19:0] rem;
    v = stg_q[StRecip];
    for (int i = 0; i < cslu_pkg::NumSdiv; i++) begin
      rem = 20'(v.num[i]) - 20'(v.quo[i]) * 20'(sd_den[i]);
      if (rem >= 20'(sd_den[i])) begin
        v.quo[i] = v.quo[i] + 16'd1;
      end
    end
    stg_d[StFix] = v;
  end

  // Stage 3: row and slice geometry
  always_comb begin
    work_t v;
    v = stg_q[StFix];
    v.copy_row = 20'(21'(v.quo[cslu_pkg::SD_WIDTH]) * 21'(bb_q));
    v.pitch    = (rl_q != 15'd0) ? 20'(21'(v.quo[cslu_pkg::SD_ROW_LEN]) * 21'(bb_q))
                                 : v.copy_row;
    v.crows    = v.h_nz ? 15'(v.quo[cslu_pkg::SD_HEIGHT]) : 15'd1;
    v.srows    = (v.h_nz && bh_q != 4'd0 && ih_q != 15'd0)
               ? 15'(v.quo[cslu_pkg::SD_IMG_HEIGHT]) : v.crows;
    v.slices   = v.d_nz ? 12'(v.quo[cslu_pkg::SD_DEPTH]) : 12'd1;
    v.skip_a   = 20'(21'(v.quo[cslu_pkg::SD_SKIP_PX]) * 21'(bb_q));
    stg_d[StLayout] = v;
  end

  // Stage 4: per-slice products
  always_comb begin
    work_t v;
    v = stg_q[StLayout];
    v.skip_b      = (v.h_nz && bh_q != 4'd0)
                  ? 35'(v.quo[cslu_pkg::SD_SKIP_ROWS]) * 35'(v.pitch) : 35'd0;
    v.slice_bytes = 35'(v.pitch) * 35'(v.srows);
    v.pc          = 35'(v.pitch) * 35'(v.crows);
    v.n1          = (v.d_nz && bd_q != 3'd0) ? v.simg : 12'd0;
    stg_d[StProd] = v;
  end

  // Stage 5: image-count products, dividends of the depth divider
  always_comb begin
    work_t v;
    v = stg_q[StProd];
    v.x1  = 48'(v.n1) * 48'(v.slice_bytes);
    v.x2  = 48'(v.d) * 48'(v.slice_bytes);
    v.sab = 36'(v.skip_a) + 36'(v.skip_b);
    v.r1  = 3'd0;
    v.r2  = 3'd0;
    stg_d[StWide] = v;
  end

  // Depth divider: each stage shifts four dividend bits into the remainder
  // and shifts the quotient bits in at the bottom of the same word.
  for (genvar g = 0; g < cslu_pkg::LdivStages; g++) begin : g_div
    always_comb begin
      work_t      v;
      logic [3:0] t1;
      logic [3:0] t2;
      v = stg_q[StDiv0 + g - 1];
      for (int i = 0; i < cslu_pkg::LdivDigit; i++) begin
        t1   = {v.r1, v.x1[DivMsb]};
        v.x1 = {v.x1[DivMsb-1:0], 1'b0};
        if (t1 >= {1'b0, bd1}) begin
          t1      = t1 - {1'b0, bd1};
          v.x1[0] = 1'b1;
        end
        v.r1 = t1[2:0];
        t2   = {v.r2, v.x2[DivMsb]};
        v.x2 = {v.x2[DivMsb-1:0], 1'b0};
        if (t2 >= {1'b0, bd1}) begin
          t2      = t2 - {1'b0, bd1};
          v.x2[0] = 1'b1;
        end
        v.r2 = t2[2:0];
      end
      stg_d[StDiv0 + g] = v;
    end
  end

  // Partial sums
  always_comb begin
    work_t v;
    v = stg_q[StSum - 1];
    v.skip  = 48'(v.sab) + v.x1;
    v.tpart = v.x2 + 48'(v.pc);
    stg_d[StSum] = v;
  end

  // Output register
  always_comb begin
    work_t v;
    v     = stg_q[StSum];
    out_d = '0;
    out_d.fast_path = v.fast;
    if (v.fast) begin
      out_d.total_bytes = 48'(v.given);
    end else begin
      out_d.skip_offset      = v.skip;
      out_d.copy_row_bytes   = v.copy_row[18:0];
      out_d.row_pitch        = v.pitch[18:0];
      out_d.copy_rows        = v.crows;
      out_d.slice_rows       = v.srows;
      out_d.copy_slice_count = v.slices;
      out_d.total_bytes      = v.skip + v.tpart;
    end
  end

  // Assertions
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StSum-1] |-> (stg_q[StSum-1].r1 < bd1) && (stg_q[StSum-1].r2 < bd1))
    else $error("depth divider remainder not below the divisor");

  a_strided_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.item.fast_path |->
      (out_o.item.copy_rows != 15'd0) && (out_o.item.slice_rows != 15'd0) &&
      (out_o.item.copy_slice_count != 12'd0))
    else $error("strided result with a zero row or slice count");

  a_default_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.item.fast_path && rl_q == 15'd0 |->
      out_o.item.row_pitch == out_o.item.copy_row_bytes)
    else $error("row pitch differs from copied row bytes without a row length");

  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item.fast_path |->
      (out_o.item.skip_offset == 48'd0) && (out_o.item.total_bytes[47:31] == 17'd0))
    else $error("fast path result carries a layout");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compressed subimage unpack layout: testbench
// Drives upload requests under a series of block formats and unpack settings,
// predicts the fast-path decision and the strided copy layout for each
// request, and checks every layout result in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned NumPhases   = 13;
  localparam int unsigned PhaseItems  = 54;

  typedef bit [63:0] u64_t;

  // One full set of register values, in the order of the register indexes.
  typedef struct packed {
    bit [14:0] block_bytes;
    bit [14:0] block_w;
    bit [14:0] block_h;
    bit [14:0] block_d;
    bit [14:0] skip_px;
    bit [14:0] row_len;
    bit [14:0] skip_row_count;
    bit [14:0] img_height;
  } unpack_setting_t;

  class layout_checker;
    bit [4:0]            block_bytes    = 5'd0;
    bit [3:0]            block_w        = 4'd1;
    bit [3:0]            block_h        = 4'd1;
    bit [2:0]            block_d        = 3'd1;
    bit [14:0]           skip_px        = '0;
    bit [14:0]           row_len        = '0;
    bit [14:0]           skip_row_count = '0;
    bit [14:0]           img_height     = '0;
    cslu_pkg::out_item_t expected_layouts[$];
    int unsigned         errors         = 0;

    function void write_reg(cslu_pkg::cfg_idx_e idx, bit [14:0] data);
      case (idx)
        cslu_pkg::CFG_BLOCK_BYTES:    block_bytes    = data[4:0];
        cslu_pkg::CFG_BLOCK_W:        block_w        = data[3:0];
        cslu_pkg::CFG_BLOCK_H:        block_h        = data[3:0];
        cslu_pkg::CFG_BLOCK_D:        block_d        = data[2:0];
        cslu_pkg::CFG_SKIP_PX:        skip_px        = data;
        cslu_pkg::CFG_ROW_LEN:        row_len        = data;
        cslu_pkg::CFG_SKIP_ROW_COUNT: skip_row_count = data;
        cslu_pkg::CFG_IMG_HEIGHT:     img_height     = data;
        default: ;
      endcase
    endfunction

    function u64_t ceil_div(u64_t a, u64_t b);
      if (b == 0) b = 1;
      return (a + b - 1) / b;
    endfunction

    function cslu_pkg::out_item_t predict_layout(cslu_pkg::in_item_t req);
      u64_t                w, h, d, simg, bb, bw, bh, bd, bd1;
      u64_t                copy_row, pitch, crows, srows, slices, skip, total;
      bit                  fast;
      cslu_pkg::out_item_t res;
      w    = 64'(req.tex_width);
      h    = 64'(req.tex_height);
      d    = 64'(req.tex_depth);
      simg = 64'(req.skip_img);
      bb   = 64'(block_bytes);
      bw   = 64'(block_w);
      bh   = 64'(block_h);
      bd   = 64'(block_d);
      res  = '0;

      // The unpack settings only matter in the dimensions the upload has.
      if (!req.subimage_ok || bb == 0 || bw == 0) fast = 1'b1;
      else if (skip_px != 0 || (w > 0 && row_len > 0 && w < 64'(row_len))) fast = 1'b0;
      else if (h == 0 || bh == 0) fast = 1'b1;
      else if (skip_row_count != 0 || (img_height > 0 && h < 64'(img_height))) fast = 1'b0;
      else if (d == 0 || bd == 0) fast = 1'b1;
      else fast = (simg == 0);

      if (fast) begin
        res.fast_path   = 1'b1;
        res.total_bytes = 48'(req.given_size);
        return res;
      end

      bd1      = (bd != 0) ? bd : 64'd1;
      copy_row = ceil_div(w, bw) * bb;
      pitch    = (row_len != 0) ? bb * ceil_div(64'(row_len), bw) : copy_row;
      crows    = (h > 0) ? ceil_div(h, bh) : 64'd1;
      srows    = crows;
      slices   = (d > 0) ? ceil_div(d, bd) : 64'd1;
      skip     = ((bw != 0) ? 64'(skip_px) / bw : 64'(skip_px)) * bb;
      if (h > 0 && bh > 0) begin
        skip += (64'(skip_row_count) / bh) * pitch;
        if (img_height != 0) srows = ceil_div(64'(img_height), bh);
      end
      if (d > 0 && bd > 0) skip += simg * pitch * srows / bd;
      total = skip + d * pitch * srows / bd1 + pitch * crows;

      res.skip_offset      = skip[47:0];
      res.copy_row_bytes   = copy_row[18:0];
      res.row_pitch        = pitch[18:0];
      res.copy_rows        = crows[14:0];
      res.slice_rows       = srows[14:0];
      res.copy_slice_count = slices[11:0];
      res.total_bytes      = total[47:0];
      return res;
    endfunction

    function void note_request(cslu_pkg::in_item_t req);
      expected_layouts.push_back(predict_layout(req));
    endfunction

    function void compare_field(string name, u64_t want, u64_t got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_layout(cslu_pkg::out_item_t got);
      cslu_pkg::out_item_t want;
      if (expected_layouts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
        return;
      end
      want = expected_layouts.pop_front();
      compare_field("fast_path", 64'(want.fast_path), 64'(got.fast_path));
      compare_field("skip_offset", 64'(want.skip_offset), 64'(got.skip_offset));
      compare_field("copy_row_bytes", 64'(want.copy_row_bytes), 64'(got.copy_row_bytes));
      compare_field("row_pitch", 64'(want.row_pitch), 64'(got.row_pitch));
      compare_field("copy_rows", 64'(want.copy_rows), 64'(got.copy_rows));
      compare_field("slice_rows", 64'(want.slice_rows), 64'(got.slice_rows));
      compare_field("copy_slice_count", 64'(want.copy_slice_count),
                    64'(got.copy_slice_count));
      compare_field("total_bytes", 64'(want.total_bytes), 64'(got.total_bytes));
    endfunction

    function int unsigned pending();
      return expected_layouts.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [cslu_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [cslu_pkg::CfgDataW-1:0] cfg_data_i;

  cslu_in_if  in_ch ();
  cslu_out_if out_ch ();

  layout_checker layout_chk = new;

  compressed_subimage_unpack_layout_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sometimes zero, sometimes the top of the range, often small, else anywhere.
  function automatic int unsigned pick_value(int unsigned hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 16) return hi;
    if (r < 55) return $urandom_range((hi < 64) ? hi : 64, 1);
    return $urandom_range(hi, 0);
  endfunction

  function automatic int unsigned idle_gap(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic cslu_pkg::in_item_t make_request(int unsigned w, int unsigned h,
                                                      int unsigned d, int unsigned given,
                                                      bit sub, int unsigned simg);
    cslu_pkg::in_item_t req;
    req.tex_width   = w[14:0];
    req.tex_height  = h[14:0];
    req.tex_depth   = d[11:0];
    req.given_size  = given[30:0];
    req.subimage_ok = sub;
    req.skip_img    = simg[11:0];
    return req;
  endfunction

  function automatic cslu_pkg::in_item_t random_request();
    return make_request(pick_value(16384), pick_value(16384), pick_value(2048),
                        pick_value(32'h7FFF_FFFF), $urandom_range(9) != 0,
                        $urandom_range(1) ? 0 : pick_value(2048));
  endfunction

  function automatic unpack_setting_t random_setting();
    unpack_setting_t s;
    s.block_bytes    = 15'(pick_value(16));
    s.block_w        = 15'(pick_value(12));
    s.block_h        = 15'(pick_value(12));
    s.block_d        = 15'(pick_value(6));
    s.skip_px        = $urandom_range(1) ? 15'd0 : 15'(pick_value(16384));
    s.row_len        = 15'(pick_value(16384));
    s.skip_row_count = $urandom_range(1) ? 15'd0 : 15'(pick_value(16384));
    s.img_height     = 15'(pick_value(16384));
    return s;
  endfunction

  // Leaves valid high after the transfer; the caller's next drive decides.
  task automatic send_request(cslu_pkg::in_item_t req, int unsigned gap);
    bit took;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= req;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Registers change only with the pipeline empty.
  task automatic program_regs(unpack_setting_t s);
    cslu_pkg::cfg_idx_e idx;
    bit [14:0]          data;
    in_ch.valid <= 1'b0;
    while (layout_chk.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    idx = idx.first();
    do begin
      case (idx)
        cslu_pkg::CFG_BLOCK_BYTES:    data = s.block_bytes;
        cslu_pkg::CFG_BLOCK_W:        data = s.block_w;
        cslu_pkg::CFG_BLOCK_H:        data = s.block_h;
        cslu_pkg::CFG_BLOCK_D:        data = s.block_d;
        cslu_pkg::CFG_SKIP_PX:        data = s.skip_px;
        cslu_pkg::CFG_ROW_LEN:        data = s.row_len;
        cslu_pkg::CFG_SKIP_ROW_COUNT: data = s.skip_row_count;
        default:                      data = s.img_height;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data;
      layout_chk.write_reg(idx, data);
      @(posedge clk_i);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we_i <= 1'b0;
  endtask

  // A transfer on either side counts at the edge after these sampled values.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) layout_chk.note_request(in_ch.item);
      if (out_ch.valid && out_ch.ready) layout_chk.check_layout(out_ch.item);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(negedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : result_ready
    int unsigned span;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      span = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(8, 1);
      out_ch.ready <= 1'b1;
      repeat (span) @(posedge clk_i);
      span = idle_gap(1'b0);
      if (span != 0) begin
        out_ch.ready <= 1'b0;
        repeat (span) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    unpack_setting_t s;
    bit              burst;
    in_ch.valid <= 1'b0;
    in_ch.item  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= cslu_pkg::CFG_BLOCK_BYTES;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset format has zero block bytes, so everything passes through.
    send_request(make_request(16384, 16384, 2048, 32'h7FFF_FFFF, 1'b1, 2048), idle_gap(0));
    send_request(make_request(0, 0, 0, 0, 1'b1, 0), idle_gap(0));

    // 4x4x2 blocks of 16 bytes, row length 64, image height 32.
    program_regs(unpack_setting_t'{15'd16, 15'd4, 15'd4, 15'd2, 15'd0, 15'd64, 15'd0,
                                   15'd32});
    send_request(make_request(16384, 16384, 2048, 32'h7FFF_FFFF, 1'b1, 0), idle_gap(0));
    send_request(make_request(16384, 16384, 2048, 32'h7FFF_FFFF, 1'b1, 2048), idle_gap(0));
    send_request(make_request(8, 16, 4, 1000, 1'b0, 3), idle_gap(0));
    send_request(make_request(8, 16, 0, 77, 1'b1, 0), idle_gap(0));
    send_request(make_request(0, 0, 0, 5, 1'b1, 0), idle_gap(0));
    send_request(make_request(64, 16, 0, 9, 1'b1, 0), idle_gap(0));
    send_request(make_request(100, 40, 0, 11, 1'b1, 7), idle_gap(0));
    send_request(make_request(100, 40, 5, 12, 1'b1, 3), idle_gap(0));
    send_request(make_request(1, 1, 1, 1, 1'b1, 1), idle_gap(0));
    send_request(make_request(16383, 16383, 2047, 0, 1'b1, 2047), idle_gap(0));

    // Zero block height and depth with every skip, the row length and the image height at 16384.
    program_regs(unpack_setting_t'{15'd1, 15'd12, 15'd0, 15'd0, 15'd16384, 15'd16384,
                                   15'd16384, 15'd16384});
    send_request(make_request(16384, 0, 0, 3, 1'b1, 0), idle_gap(0));
    send_request(make_request(13, 25, 7, 4, 1'b1, 2048), idle_gap(0));
    send_request(make_request(0, 16384, 2048, 5, 1'b1, 5), idle_gap(0));
    send_request(make_request(13, 25, 7, 6, 1'b0, 1), idle_gap(0));

    // Zero block width always takes the fast path.
    program_regs(unpack_setting_t'{15'd5, 15'd0, 15'd3, 15'd2, 15'd9, 15'd500, 15'd4,
                                   15'd100});
    send_request(make_request(10, 10, 10, 42, 1'b1, 9), idle_gap(0));

    // Skip rows alone force the strided path once a height is present.
    program_regs(unpack_setting_t'{15'd16, 15'd12, 15'd12, 15'd6, 15'd0, 15'd0, 15'd5,
                                   15'd0});
    send_request(make_request(30, 0, 0, 21, 1'b1, 0), idle_gap(0));
    send_request(make_request(30, 30, 0, 22, 1'b1, 0), idle_gap(0));
    send_request(make_request(30, 30, 13, 23, 1'b1, 4), idle_gap(0));

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: s = unpack_setting_t'{15'd16, 15'd12, 15'd12, 15'd6, 15'd16384, 15'd16384,
                                 15'd16384, 15'd16384};
        1: s = '0;
        2: s = unpack_setting_t'{15'd1, 15'd1, 15'd1, 15'd1, 15'd0, 15'd0, 15'd0, 15'd0};
        default: s = random_setting();
      endcase
      program_regs(s);
      burst = ($urandom_range(3) == 0);
      repeat (PhaseItems) send_request(random_request(), idle_gap(burst));
    end

    in_ch.valid <= 1'b0;
    while (layout_chk.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (layout_chk.errors == 0 && layout_chk.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
